/* rtl/magnetic_stick_autozero_deadzone_defines.svh */
// assertion helpers for the stick block checkers
`ifndef MAGNETIC_STICK_AUTOZERO_DEADZONE_DEFINES_SVH
`define MAGNETIC_STICK_AUTOZERO_DEADZONE_DEFINES_SVH

// same-cycle implication
`define MSAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msad check failed");

// next-cycle implication
`define MSAD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msad check failed");

`endif

/* rtl/msad_pkg.sv */
package msad_pkg;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int FIELD_W = 16;
	localparam int SUM_W = 32;
	localparam int NUM_AXES = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam logic [FIELD_W-1:0] TRIM_Q16 = 16'd58327;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXIS_ENABLE,
		CFG_CALIB_COUNT,
		CFG_EXTRA_XY,
		CFG_EXTRA_Z,
		CFG_DOWNSHIFT,
		CFG_DEADZONE_X,
		CFG_DEADZONE_Y,
		CFG_DEADZONE_Z
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_NONE,
		REQ_WAKE,
		REQ_BURST,
		REQ_DOWNSHIFT
	} mode_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DSTART,
		ST_DIV,
		ST_TRIM,
		ST_THD,
		ST_MERGE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic calib_upd;
		logic delta_upd;
		logic div_start;
	} lane_ctl_t;

	function automatic logic signed [FIELD_W-1:0] sext_sample(input logic [FIELD_W-1:0] raw);
		logic signed [SAMPLE_WIDTH-1:0] t;
		t = raw[SAMPLE_WIDTH-1:0];
		return FIELD_W'(t);
	endfunction
endpackage

/* rtl/msad_ifs.sv */
interface msad_sample_if;
	import msad_pkg::*;
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] sample_x;
	logic signed [FIELD_W-1:0] sample_y;
	logic signed [FIELD_W-1:0] sample_z;
	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface msad_result_if;
	import msad_pkg::*;
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] delta_x;
	logic signed [FIELD_W-1:0] delta_y;
	logic signed [FIELD_W-1:0] delta_z;
	logic moved;
	logic [1:0] mode_request;
	logic [FIELD_W-1:0] wake_thd_xy;
	logic [FIELD_W-1:0] wake_thd_z;
	logic is_calibrated;
	modport source (output valid, delta_x, delta_y, delta_z, moved, mode_request,
		wake_thd_xy, wake_thd_z, is_calibrated, input ready);
	modport sink (input valid, delta_x, delta_y, delta_z, moved, mode_request,
		wake_thd_xy, wake_thd_z, is_calibrated, output ready);
endinterface

interface msad_cfg_if;
	import msad_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/magnetic_stick_autozero_deadzone.sv */
// magnetic stick front end with auto-zero, wake thresholds and dead zones
//
// samples: one item per three-axis field reading (valid/ready). results: one
// item per sample with deltas, moved flag, mode request, threshold words and
// the calibrated flag. cfg: register writes (index/data), always ready, to be
// issued only while no item is in flight.
// the block takes one item at a time. an ordinary item goes from the exec
// state to the out state (calibrating), or through exec and merge to out
// (calibrated); the out state loads the output register, and only then is a
// new item taken. the item that completes calibration runs the three lane
// dividers (restoring division) in parallel, then the threshold multiply.
// the result sits in an output register; a finished item waits there while the
// receiver stalls, and the next item is taken meanwhile, its result held back
// until the output register frees.
// reset clears all calibration state, the mode and the counters and loads the
// register defaults (all axes on, 64 calibration samples, downshift after 100).
module magnetic_stick_autozero_deadzone (
	input logic clk,
	input logic arst_n,
	msad_sample_if.sink samples,
	msad_result_if.source results,
	msad_cfg_if.sink cfg
);
	import msad_pkg::*;

	state_t state_q, state_d;
	lane_ctl_t ctl;
	logic load_out;

	logic [NUM_AXES-1:0] axis_en_q;
	logic [FIELD_W-1:0] calib_cnt_q, extra_xy_q, extra_z_q, downshift_q;
	logic [FIELD_W-1:0] dz_q [NUM_AXES];

	logic signed [FIELD_W-1:0] smp_s1 [NUM_AXES];
	logic signed [FIELD_W-1:0] raw [NUM_AXES];
	logic signed [FIELD_W-1:0] delta [NUM_AXES];
	logic [FIELD_W-1:0] range [NUM_AXES];
	logic [NUM_AXES-1:0] busy;

	logic cal_q, burst_q;
	logic [COUNT_WIDTH-1:0] seen_q, idle_q, seen_n, idle_n, cnt;
	logic [FIELD_W-1:0] thd_xy_q, thd_z_q, rxy;
	logic [SUM_W-1:0] prod_xy_s1, prod_z_s1;
	mode_req_t req_q;
	logic moved_q, keep_q, moved;
	logic out_valid_q;

	assign raw[0] = samples.sample_x;
	assign raw[1] = samples.sample_y;
	assign raw[2] = samples.sample_z;

	assign cnt = (calib_cnt_q[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
		: calib_cnt_q[COUNT_WIDTH-1:0];
	assign seen_n = seen_q + COUNT_WIDTH'(1);
	assign idle_n = idle_q + COUNT_WIDTH'(1);
	assign moved = (delta[0] != '0) || (delta[1] != '0) || (delta[2] != '0);
	assign rxy = (range[0] > range[1]) ? range[0] : range[1];

	assign cfg.ready = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_en_q <= 3'd7;
			calib_cnt_q <= 16'd64;
			extra_xy_q <= '0;
			extra_z_q <= '0;
			downshift_q <= 16'd100;
			for (int i = 0; i < NUM_AXES; i++)
				dz_q[i] <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_AXIS_ENABLE: axis_en_q <= cfg.data[NUM_AXES-1:0];
				CFG_CALIB_COUNT: calib_cnt_q <= cfg.data;
				CFG_EXTRA_XY: extra_xy_q <= cfg.data;
				CFG_EXTRA_Z: extra_z_q <= cfg.data;
				CFG_DOWNSHIFT: downshift_q <= cfg.data;
				CFG_DEADZONE_X: dz_q[0] <= cfg.data;
				CFG_DEADZONE_Y: dz_q[1] <= cfg.data;
				CFG_DEADZONE_Z: dz_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// disabled axes read as zero
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready)
			for (int i = 0; i < NUM_AXES; i++)
				smp_s1[i] <= axis_en_q[i] ? sext_sample(raw[i]) : '0;
	end

	genvar g;
	generate
		for (g = 0; g < NUM_AXES; g++) begin : g_lane
			msad_lane u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.smp(smp_s1[g]),
				.cnt(cnt),
				.deadzone(dz_q[g]),
				.delta(delta[g]),
				.range(range[g]),
				.div_busy(busy[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: if (samples.valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (!cal_q) begin
					ctl.calib_upd = 1'b1;
					state_d = (seen_n >= cnt) ? ST_DSTART : ST_OUT;
				end else begin
					ctl.delta_upd = 1'b1;
					state_d = ST_MERGE;
				end
			end
			ST_DSTART: begin
				ctl.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: if (busy == '0) state_d = ST_TRIM;
			ST_TRIM: state_d = ST_THD;
			ST_THD: state_d = ST_OUT;
			ST_MERGE: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b0;
			burst_q <= 1'b0;
			seen_q <= '0;
			idle_q <= '0;
			thd_xy_q <= '0;
			thd_z_q <= '0;
			req_q <= REQ_NONE;
			moved_q <= 1'b0;
			keep_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (!cal_q) begin
						seen_q <= seen_n;
						req_q <= REQ_NONE;
						moved_q <= 1'b0;
						keep_q <= 1'b0;
					end
				end
				ST_THD: begin
					thd_xy_q <= prod_xy_s1[SUM_W-1:FIELD_W] + extra_xy_q;
					thd_z_q <= prod_z_s1[SUM_W-1:FIELD_W] + extra_z_q;
					cal_q <= 1'b1;
					burst_q <= 1'b0;
					req_q <= REQ_WAKE;
				end
				ST_MERGE: begin
					moved_q <= moved;
					keep_q <= 1'b1;
					req_q <= REQ_NONE;
					// idle counter holds across motion in burst mode; motion does not clear it
					if (!moved && burst_q) begin
						if (idle_n >= downshift_q[COUNT_WIDTH-1:0]) begin
							idle_q <= '0;
							burst_q <= 1'b0;
							req_q <= REQ_DOWNSHIFT;
						end else begin
							idle_q <= idle_n;
						end
					end else if (moved && !burst_q) begin
						burst_q <= 1'b1;
						req_q <= REQ_BURST;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TRIM) begin
			prod_xy_s1 <= SUM_W'(rxy) * SUM_W'(TRIM_Q16);
			prod_z_s1 <= SUM_W'(range[2]) * SUM_W'(TRIM_Q16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			results.delta_x <= keep_q ? delta[0] : '0;
			results.delta_y <= keep_q ? delta[1] : '0;
			results.delta_z <= keep_q ? delta[2] : '0;
			results.moved <= moved_q;
			results.mode_request <= req_q;
			results.wake_thd_xy <= thd_xy_q;
			results.wake_thd_z <= thd_z_q;
			results.is_calibrated <= cal_q;
		end
	end
endmodule

/* rtl/msad_div.sv */
module msad_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [msad_pkg::SUM_W-1:0] dividend,
	input logic [msad_pkg::COUNT_WIDTH-1:0] divisor,
	output logic busy,
	output logic signed [msad_pkg::FIELD_W-1:0] quotient
);
	import msad_pkg::*;

	logic [SUM_W-1:0] mag_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic neg_q;
	logic busy_q;
	logic [COUNT_WIDTH:0] trial;
	logic take;
	logic [SUM_W-1:0] mag_next;
	logic [SUM_W-1:0] signed_res;

	// restoring divide, one quotient bit per cycle, on the magnitude
	always_comb begin
		trial = {rem_q, mag_q[SUM_W-1]};
		take = trial >= {1'b0, divisor};
		mag_next = {mag_q[SUM_W-2:0], take};
		signed_res = neg_q ? (~mag_next + SUM_W'(1)) : mag_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(SUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_next;
			rem_q <= take ? COUNT_WIDTH'(trial - {1'b0, divisor}) : trial[COUNT_WIDTH-1:0];
			if (cnt_q == DIV_CNT_W'(SUM_W - 1))
				quotient <= signed_res[FIELD_W-1:0];
		end
	end

	assign busy = busy_q;
endmodule

/* rtl/msad_lane.sv */
module msad_lane (
	input logic clk,
	input logic arst_n,
	input msad_pkg::lane_ctl_t ctl,
	input logic signed [msad_pkg::FIELD_W-1:0] smp,
	input logic [msad_pkg::COUNT_WIDTH-1:0] cnt,
	input logic [msad_pkg::FIELD_W-1:0] deadzone,
	output logic signed [msad_pkg::FIELD_W-1:0] delta,
	output logic [msad_pkg::FIELD_W-1:0] range,
	output logic div_busy
);
	import msad_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [FIELD_W-1:0] min_q;
	logic signed [FIELD_W-1:0] max_q;
	logic signed [FIELD_W-1:0] origin;
	logic signed [FIELD_W-1:0] delta_q;
	logic [FIELD_W-1:0] v;
	logic [FIELD_W-1:0] mag;

	msad_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(ctl.div_start),
		.dividend(sum_q),
		.divisor(cnt),
		.busy(div_busy),
		.quotient(origin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= 16'sh7fff;
			max_q <= 16'sh8000;
		end else if (ctl.calib_upd) begin
			sum_q <= sum_q + SUM_W'(smp);
			if (smp < min_q)
				min_q <= smp;
			if (smp > max_q)
				max_q <= smp;
		end
	end

	// delta wraps to 16 bits; magnitude of -32768 is 32768 unsigned
	always_comb begin
		v = smp - origin;
		mag = v[FIELD_W-1] ? (~v + FIELD_W'(1)) : v;
	end

	always_ff @(posedge clk) begin
		if (ctl.delta_upd)
			delta_q <= (mag < deadzone) ? '0 : v;
	end

	assign range = max_q - min_q;
	assign delta = delta_q;
endmodule

/* rtl/msad_checker.sv */
`include "magnetic_stick_autozero_deadzone_defines.svh"

module msad_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic moved,
	input logic [1:0] req,
	input logic calibrated,
	input logic [msad_pkg::FIELD_W-1:0] dx,
	input logic [msad_pkg::FIELD_W-1:0] dy,
	input logic [msad_pkg::FIELD_W-1:0] dz
);
	import msad_pkg::*;

	`MSAD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`MSAD_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
	`MSAD_ASSERT_IMP(a_moved_cal, out_valid && moved, calibrated && (dx != '0 || dy != '0 || dz != '0))
	`MSAD_ASSERT_IMP(a_uncal_quiet, out_valid && (!calibrated || req == REQ_WAKE), dx == '0 && dy == '0 && dz == '0 && !moved)
endmodule

bind magnetic_stick_autozero_deadzone msad_checker u_msad_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.moved(results.moved),
	.req(results.mode_request),
	.calibrated(results.is_calibrated),
	.dx(results.delta_x),
	.dy(results.delta_y),
	.dz(results.delta_z)
);

/* verif/magnetic_stick_autozero_deadzone_test.sv */
module magnetic_stick_autozero_deadzone_test;
	import msad_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_ITEMS = 240;

	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic moved;
		mode_req_t req;
		logic [15:0] thd_xy;
		logic [15:0] thd_z;
		logic cal;
	} stick_res_t;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_idx_t idx;
		logic [15:0] val;
		logic signed [15:0] x, y, z;
		logic typed;
		stick_res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	msad_sample_if samp_if ();
	msad_result_if res_if ();
	msad_cfg_if cfg_if ();

	magnetic_stick_autozero_deadzone uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samp_if.sink),
		.results(res_if.source),
		.cfg(cfg_if.sink)
	);

	// mirror of the register file
	logic [2:0] m_enable;
	logic [15:0] m_calib_cnt, m_extra_xy, m_extra_z, m_downshift;
	logic [15:0] m_dz [3];

	// mirror of the calibration and mode state
	logic m_calibrated;
	logic [15:0] m_seen;
	int m_sum [3];
	int m_min [3];
	int m_max [3];
	logic signed [15:0] m_origin [3];
	logic [15:0] m_thd_xy, m_thd_z;
	logic m_burst;
	logic [15:0] m_idle_cnt;

	stick_res_t pending_results[$];
	stim_row_t stim_rows[$];
	int mismatches = 0;
	int n_results = 0, n_wake = 0, n_burst = 0, n_down = 0, n_moved = 0;
	int cycles = 0;
	logic steady = 1'b0;

	function automatic logic [15:0] trim_thd(int unsigned range, logic [15:0] extra);
		int unsigned prod;
		prod = (range * 32'd58327) >> 16;
		return 16'(prod + extra);
	endfunction

	function automatic void mirror_cfg(cfg_idx_t idx, logic [15:0] val);
		case (idx)
			CFG_AXIS_ENABLE: m_enable = val[2:0];
			CFG_CALIB_COUNT: m_calib_cnt = val;
			CFG_EXTRA_XY: m_extra_xy = val;
			CFG_EXTRA_Z: m_extra_z = val;
			CFG_DOWNSHIFT: m_downshift = val;
			CFG_DEADZONE_X: m_dz[0] = val;
			CFG_DEADZONE_Y: m_dz[1] = val;
			CFG_DEADZONE_Z: m_dz[2] = val;
			default: ;
		endcase
	endfunction

	function automatic stick_res_t step_stick(logic signed [15:0] x, y, z);
		stick_res_t r;
		int s [3];
		logic signed [15:0] raw [3];
		logic signed [15:0] v;
		int cnt, mag;
		int unsigned rng [3];
		int unsigned rxy;
		raw[0] = x;
		raw[1] = y;
		raw[2] = z;
		r = '0;
		r.req = REQ_NONE;
		for (int i = 0; i < 3; i++)
			s[i] = m_enable[i] ? int'(raw[i]) : 0;
		if (!m_calibrated) begin
			cnt = (m_calib_cnt == 0) ? 1 : int'(m_calib_cnt);
			for (int i = 0; i < 3; i++) begin
				m_sum[i] += s[i];
				if (s[i] < m_min[i]) m_min[i] = s[i];
				if (s[i] > m_max[i]) m_max[i] = s[i];
			end
			m_seen = m_seen + 16'd1;
			if (int'(m_seen) >= cnt) begin
				for (int i = 0; i < 3; i++) begin
					m_origin[i] = 16'(m_sum[i] / cnt);
					rng[i] = (m_max[i] - m_min[i]) & 32'hFFFF;
				end
				rxy = (rng[0] > rng[1]) ? rng[0] : rng[1];
				m_thd_xy = trim_thd(rxy, m_extra_xy);
				m_thd_z = trim_thd(rng[2], m_extra_z);
				m_calibrated = 1'b1;
				m_burst = 1'b0;
				r.req = REQ_WAKE;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				v = 16'(s[i] - int'(m_origin[i]));
				mag = (v < 0) ? -int'(v) : int'(v);
				raw[i] = (mag < int'(m_dz[i])) ? 16'sd0 : v;
			end
			r.dx = raw[0];
			r.dy = raw[1];
			r.dz = raw[2];
			r.moved = (raw[0] != 0) || (raw[1] != 0) || (raw[2] != 0);
			if (!r.moved && m_burst) begin
				m_idle_cnt = m_idle_cnt + 16'd1;
				if (m_idle_cnt >= m_downshift) begin
					m_idle_cnt = '0;
					m_burst = 1'b0;
					r.req = REQ_DOWNSHIFT;
				end
			end else if (r.moved && !m_burst) begin
				m_burst = 1'b1;
				r.req = REQ_BURST;
			end
		end
		r.thd_xy = m_thd_xy;
		r.thd_z = m_thd_z;
		r.cal = m_calibrated;
		return r;
	endfunction

	task automatic wait_idle();
		samp_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		mirror_cfg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [15:0] x, y, z, logic typed, stick_res_t want);
		stick_res_t p;
		if (!steady && $urandom_range(99) < 19) begin
			samp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		samp_if.valid <= 1'b1;
		samp_if.sample_x <= x;
		samp_if.sample_y <= y;
		samp_if.sample_z <= z;
		do @(posedge clk); while (!samp_if.ready);
		p = step_stick(x, y, z);
		pending_results.push_back(typed ? want : p);
	endtask

	function automatic void add_cfg(cfg_idx_t idx, logic [15:0] val);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, val: val, x: 0, y: 0, z: 0, typed: 0, want: '0};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_smp(logic signed [15:0] x, y, z, logic typed);
		stim_row_t r;
		r = '{kind: ROW_SAMPLE, idx: CFG_AXIS_ENABLE, val: 0, x: x, y: y, z: z,
			typed: typed, want: '0};
		r.want.req = REQ_NONE;
		stim_rows.push_back(r);
	endfunction

	function automatic logic signed [15:0] near_origin(int a, int span);
		if (span < 0)
			return 16'($urandom);
		return 16'(int'(m_origin[a]) + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [15:0] pick_dz();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd1;
			default: return 16'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic logic [15:0] pick_downshift();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		stick_res_t got, want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.dx = res_if.delta_x;
			got.dy = res_if.delta_y;
			got.dz = res_if.delta_z;
			got.moved = res_if.moved;
			got.req = mode_req_t'(res_if.mode_request);
			got.thd_xy = res_if.wake_thd_xy;
			got.thd_z = res_if.wake_thd_z;
			got.cal = res_if.is_calibrated;
			n_results++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (want.req == REQ_WAKE) n_wake++;
				if (want.req == REQ_BURST) n_burst++;
				if (want.req == REQ_DOWNSHIFT) n_down++;
				if (want.moved) n_moved++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		res_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		samp_if.valid = 1'b0;
		samp_if.sample_x = '0;
		samp_if.sample_y = '0;
		samp_if.sample_z = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_AXIS_ENABLE;
		cfg_if.data = '0;
		m_enable = 3'd7;
		m_calib_cnt = 16'd64;
		m_extra_xy = '0;
		m_extra_z = '0;
		m_downshift = 16'd100;
		m_calibrated = 1'b0;
		m_seen = '0;
		m_thd_xy = '0;
		m_thd_z = '0;
		m_burst = 1'b0;
		m_idle_cnt = '0;
		for (int i = 0; i < 3; i++) begin
			m_dz[i] = '0;
			m_sum[i] = 0;
			m_min[i] = 32767;
			m_max[i] = -32768;
			m_origin[i] = '0;
		end

		// calibration with extreme samples, two disabled axes, then the count
		// dropped below the samples already seen
		add_cfg(CFG_AXIS_ENABLE, 16'd7);
		add_cfg(CFG_CALIB_COUNT, 16'hFFFF);
		add_cfg(CFG_EXTRA_XY, 16'hFFFF);
		add_cfg(CFG_EXTRA_Z, 16'd0);
		add_smp(16'sh7FFF, -16'sh8000, 16'sd0, 1);
		add_smp(-16'sh8000, 16'sh7FFF, -16'sd1, 1);
		add_smp(16'sd0, 16'sd0, 16'sh7FFF, 1);
		add_smp(16'sd1, -16'sd1, -16'sh8000, 1);
		add_cfg(CFG_AXIS_ENABLE, 16'd2);
		add_smp(16'sd5000, 16'sd6000, 16'sd7000, 1);
		add_cfg(CFG_AXIS_ENABLE, 16'd7);
		add_cfg(CFG_CALIB_COUNT, 16'd3);
		add_smp(16'sd123, -16'sd77, 16'sd9, 0);
		// dead zones, burst entry and the downshift setting
		add_cfg(CFG_DEADZONE_X, 16'd100);
		add_cfg(CFG_DEADZONE_Y, 16'hFFFF);
		add_cfg(CFG_DEADZONE_Z, 16'd0);
		add_cfg(CFG_DOWNSHIFT, 16'd2);
		add_smp(16'sd0, 16'sd0, 16'sd0, 0);
		add_smp(16'sh7FFF, 16'sh7FFF, 16'sd0, 0);
		add_smp(-16'sh8000, -16'sh8000, -16'sh8000, 0);
		add_smp(16'sd0, 16'sd0, 16'sd0, 0);
		add_smp(16'sd50, 16'sd1, 16'sd0, 0);
		add_smp(16'sd0, 16'sd0, 16'sd0, 0);
		add_cfg(CFG_DOWNSHIFT, 16'd0);
		add_cfg(CFG_CALIB_COUNT, 16'd0);
		add_cfg(CFG_EXTRA_Z, 16'hFFFF);
		add_smp(16'sh7FFF, 16'sd0, 16'sh7FFF, 0);
		add_smp(16'sd0, 16'sd0, 16'sd0, 0);
		add_smp(-16'sd1, 16'sd300, 16'sd0, 0);
		add_cfg(CFG_AXIS_ENABLE, 16'd0);
		add_smp(16'sd1234, -16'sd4321, 16'sd1, 0);
		add_smp(16'sd0, 16'sd0, 16'sd0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(stim_rows[i].idx, stim_rows[i].val);
			end else begin
				send_sample(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
					stim_rows[i].typed, stim_rows[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			int span;
			wait_idle();
			write_reg(CFG_AXIS_ENABLE, (ph == 0) ? 16'd7 : 16'($urandom_range(0, 7)));
			write_reg(CFG_DEADZONE_X, pick_dz());
			write_reg(CFG_DEADZONE_Y, pick_dz());
			write_reg(CFG_DEADZONE_Z, pick_dz());
			write_reg(CFG_DOWNSHIFT, pick_downshift());
			steady = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// runs of quiet samples near the origin let the downshift counter climb
				case ($urandom_range(9))
					0, 1: span = -1;
					2, 3: span = 400;
					4: span = 0;
					default: span = 80;
				endcase
				send_sample(near_origin(0, span), near_origin(1, span), near_origin(2, span),
					1'b0, '0);
			end
			steady = 1'b0;
		end

		samp_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d result items: %0d with motion, %0d calibration done",
			n_results, n_moved, n_wake);
		$display("mode changes seen: %0d into burst, %0d back to wake", n_burst, n_down);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/msad_pkg.sv
rtl/msad_ifs.sv
rtl/msad_div.sv
rtl/msad_lane.sv
rtl/magnetic_stick_autozero_deadzone.sv
rtl/msad_checker.sv
verif/magnetic_stick_autozero_deadzone_test.sv
